### design/duration_arithmetic_unit_core_defines.svh
// Assertion helpers for the duration arithmetic unit.
`ifndef DURATION_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define DURATION_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Checked only outside reset.
`define DAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/dau_pkg.sv
package dau_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [29:0] NS_MAX     = 30'd999999999;
    localparam int          DivSteps   = 64;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t        mode;
        logic [63:0]  a_secs;
        logic [29:0]  a_nanos;
        logic [63:0]  b_secs;
        logic [29:0]  b_nanos;
        logic [63:0]  factor;
    } req_t;

    typedef struct packed {
        logic [63:0]  res_secs;
        logic [29:0]  res_nanos;
        logic         div_zero;
    } rsp_t;

    // Work item carried down the pipeline.
    typedef struct packed {
        mode_t        mode;
        logic         dz;
        logic [63:0]  a_secs;
        logic [29:0]  a_nanos;
        logic [63:0]  factor;
        logic [63:0]  sum_secs;
        logic [29:0]  sum_nanos;
        logic [63:0]  qa;       // a_secs / factor
        logic [63:0]  ra;       // a_secs % factor
        logic [29:0]  qn;       // a_nanos / factor
        logic [63:0]  rn;
        logic [61:0]  p_lo;
        logic [61:0]  p_hi;
        logic [63:0]  s00;
        logic [31:0]  s01;
        logic [31:0]  s10;
        logic [63:0]  asf;      // a_secs * factor mod 2^64
        logic [63:0]  dvs;      // second divisor
        logic [63:0]  lowp;     // low dividend bits of second division
        logic [63:0]  rb;
        logic [63:0]  qb;
    } work_t;

    // One restoring step: {quotient bit, new remainder}.
    function automatic logic [64:0] div_step(input logic [63:0] r, input logic b,
                                             input logic [63:0] d);
        logic [64:0] t;
        logic [64:0] s;
        t = {r, b};
        s = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            div_step = {1'b1, s[63:0]};
        end
        else
        begin
            div_step = {1'b0, t[63:0]};
        end
    endfunction

endpackage

### design/duration_arithmetic_unit_core.sv
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (req_t)
// result  | rsp_valid | rsp_stall | rsp (rsp_t)
// Stages: input stage, 64 divide stages, 2 multiply stages, 64 divide stages,
// output register. One request per cycle while the result is not stalled.
// The two bit-serial dividers set the depth; each stage is one 64-bit compare-subtract deep.
// Reset clears only the valid bits. A stalled result freezes the whole pipeline,
// so req_stall follows rsp_valid && rsp_stall.
module duration_arithmetic_unit_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dau_pkg::rsp_t rsp
);
    import dau_pkg::*;
    `include "duration_arithmetic_unit_core_defines.svh"

    logic        en;
    work_t       s0_reg;
    work_t       s0_next;
    logic        s0_v_reg;
    work_t       a_w;
    logic        a_v;
    work_t       m_w;
    logic        m_v;
    work_t       b_w;
    logic        b_v;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        rsp_v_reg;
    logic [29:0] an;
    logic [29:0] bn;
    logic [30:0] nsum;
    logic        cy;
    logic        br;
    logic [30:0] dsum;

    assign en        = !(rsp_v_reg && rsp_stall);
    assign req_stall = !en;

    always_comb
    begin
        an   = (req.a_nanos > NS_MAX) ? NS_MAX : req.a_nanos;
        bn   = (req.b_nanos > NS_MAX) ? NS_MAX : req.b_nanos;
        nsum = {1'b0, an} + {1'b0, bn};
        cy   = nsum >= {1'b0, NS_PER_SEC};
        br   = an < bn;
        s0_next         = '0;
        s0_next.mode    = req.mode;
        s0_next.dz      = (req.mode == MODE_DIV) && (req.factor == 64'd0);
        s0_next.a_secs  = req.a_secs;
        s0_next.a_nanos = an;
        s0_next.factor  = req.factor;
        if (req.mode == MODE_SUB)
        begin
            s0_next.sum_secs  = req.a_secs - req.b_secs - 64'(br);
            s0_next.sum_nanos = br ? 30'({1'b0, an} + {1'b0, NS_PER_SEC} - {1'b0, bn})
                                   : an - bn;
        end
        else
        begin
            s0_next.sum_secs  = req.a_secs + req.b_secs + 64'(cy);
            s0_next.sum_nanos = cy ? 30'(nsum - {1'b0, NS_PER_SEC}) : nsum[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            rsp_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg  <= req_valid;
            rsp_v_reg <= b_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            rsp_reg <= rsp_next;
        end
    end

    dau_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (s0_v_reg),
        .in_w  (s0_reg),
        .out_v (a_v),
        .out_w (a_w)
    );

    dau_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (a_v),
        .in_w  (a_w),
        .out_v (m_v),
        .out_w (m_w)
    );

    dau_ndiv u_ndiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (m_v),
        .in_w  (m_w),
        .out_v (b_v),
        .out_w (b_w)
    );

    always_comb
    begin
        rsp_next = '0;
        dsum     = {1'b0, b_w.qn} + {1'b0, b_w.qb[29:0]};
        case (b_w.mode) inside
            MODE_ADD, MODE_SUB:
            begin
                rsp_next.res_secs  = b_w.sum_secs;
                rsp_next.res_nanos = b_w.sum_nanos;
            end
            MODE_MUL:
            begin
                rsp_next.res_secs  = b_w.asf + b_w.qb;
                rsp_next.res_nanos = b_w.rb[29:0];
            end
            default:
            begin
                if (b_w.dz)
                begin
                    rsp_next.div_zero = 1'b1;
                end
                else if (dsum >= {1'b0, NS_PER_SEC})
                begin
                    rsp_next.res_secs  = b_w.qa + 64'd1;
                    rsp_next.res_nanos = 30'(dsum - {1'b0, NS_PER_SEC});
                end
                else
                begin
                    rsp_next.res_secs  = b_w.qa;
                    rsp_next.res_nanos = dsum[29:0];
                end
            end
        endcase
    end

    assign rsp_valid = rsp_v_reg;
    assign rsp       = rsp_reg;

    `DAU_ASSERT(a_nanos_norm, rsp_valid |-> rsp.res_nanos <= NS_MAX, "res_nanos out of range")
    `DAU_ASSERT(a_dz_zero, rsp_valid && rsp.div_zero |-> rsp.res_secs == 64'd0 && rsp.res_nanos == 30'd0, "div_zero result not zero")
    `DAU_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !rsp_valid, "result valid in reset")

endmodule

### design/dau_sdiv.sv
// Seconds and nanoseconds divided by factor, one quotient bit per stage.
module dau_sdiv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_v,
    input  dau_pkg::work_t in_w,
    output logic           out_v,
    output dau_pkg::work_t out_w
);
    import dau_pkg::*;

    work_t st_reg [DivSteps];
    logic  v_reg  [DivSteps];

    for (genvar k = 0; k < DivSteps; k++)
    begin : g_stage
        localparam int Pos = DivSteps - 1 - k;
        work_t       prev;
        work_t       st_next;
        logic        prev_v;
        logic        nbit;
        logic [64:0] sa;
        logic [64:0] sn;

        if (k == 0)
        begin : g_first
            assign prev   = in_w;
            assign prev_v = in_v;
        end
        else
        begin : g_rest
            assign prev   = st_reg[k-1];
            assign prev_v = v_reg[k-1];
        end

        if (Pos < 30)
        begin : g_nbit
            assign nbit = prev.a_nanos[Pos];
        end
        else
        begin : g_nzero
            assign nbit = 1'b0;
        end

        always_comb
        begin
            sa = div_step(prev.ra, prev.a_secs[Pos], prev.factor);
            sn = div_step(prev.rn, nbit, prev.factor);
            st_next    = prev;
            st_next.qa = {prev.qa[62:0], sa[64]};
            st_next.ra = sa[63:0];
            st_next.qn = {prev.qn[28:0], sn[64]};
            st_next.rn = sn[63:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_v = v_reg[DivSteps-1];
    assign out_w = st_reg[DivSteps-1];

endmodule

### design/dau_mul.sv
// Two-stage multiply: partial products, then sums.
module dau_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_v,
    input  dau_pkg::work_t in_w,
    output logic           out_v,
    output dau_pkg::work_t out_w
);
    import dau_pkg::*;

    work_t       m1_reg;
    work_t       m1_next;
    logic        m1_v_reg;
    work_t       m2_reg;
    work_t       m2_next;
    logic        m2_v_reg;
    logic [63:0] x;
    logic [29:0] y;
    logic [93:0] prod;

    always_comb
    begin
        // mode MUL: a_nanos * factor; other modes: (a_secs % factor) * 1e9
        x = (in_w.mode == MODE_MUL) ? in_w.factor : in_w.ra;
        y = (in_w.mode == MODE_MUL) ? in_w.a_nanos : NS_PER_SEC;
        m1_next      = in_w;
        m1_next.p_lo = 62'(x[31:0]) * 62'(y);
        m1_next.p_hi = 62'(x[63:32]) * 62'(y);
        m1_next.s00  = 64'(in_w.a_secs[31:0]) * 64'(in_w.factor[31:0]);
        m1_next.s01  = in_w.a_secs[31:0] * in_w.factor[63:32];
        m1_next.s10  = in_w.a_secs[63:32] * in_w.factor[31:0];
    end

    always_comb
    begin
        prod = 94'(m1_reg.p_lo) + {m1_reg.p_hi, 32'd0};
        m2_next      = m1_reg;
        m2_next.asf  = m1_reg.s00 + {m1_reg.s01 + m1_reg.s10, 32'd0};
        m2_next.rb   = 64'(prod[93:64]);
        m2_next.lowp = prod[63:0];
        m2_next.qb   = '0;
        m2_next.dvs  = (m1_reg.mode == MODE_MUL) ? 64'(NS_PER_SEC) : m1_reg.factor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= in_v;
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

    assign out_v = m2_v_reg;
    assign out_w = m2_reg;

endmodule

### design/dau_ndiv.sv
// Product divided by 1e9 (multiply) or by factor (divide), one bit per stage.
module dau_ndiv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_v,
    input  dau_pkg::work_t in_w,
    output logic           out_v,
    output dau_pkg::work_t out_w
);
    import dau_pkg::*;

    work_t st_reg [DivSteps];
    logic  v_reg  [DivSteps];

    for (genvar k = 0; k < DivSteps; k++)
    begin : g_stage
        localparam int Pos = DivSteps - 1 - k;
        work_t       prev;
        work_t       st_next;
        logic        prev_v;
        logic [64:0] sb;

        if (k == 0)
        begin : g_first
            assign prev   = in_w;
            assign prev_v = in_v;
        end
        else
        begin : g_rest
            assign prev   = st_reg[k-1];
            assign prev_v = v_reg[k-1];
        end

        always_comb
        begin
            sb = div_step(prev.rb, prev.lowp[Pos], prev.dvs);
            st_next    = prev;
            st_next.qb = {prev.qb[62:0], sb[64]};
            st_next.rb = sb[63:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_v = v_reg[DivSteps-1];
    assign out_w = st_reg[DivSteps-1];

endmodule
